/* src/disc_track_table_lba_mapper_macros.svh */
// Assertion macros shared by the track table mapper RTL.
// Every macro expects clk_i and rst_ni to be visible where it is used.
`ifndef DISC_TRACK_TABLE_LBA_MAPPER_MACROS_SVH
`define DISC_TRACK_TABLE_LBA_MAPPER_MACROS_SVH

// The condition must never hold outside reset.
`define DTTL_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define DTTL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DTTL_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/dttl_pkg.sv */
// Types, constants and helpers of the track table mapper.
// Used by every module of the block; depends on nothing.
package dttl_pkg;

  localparam int MAX_ENTRIES_DEF = 128;
  localparam int QUEUE_DEPTH     = 2;

  localparam int FRAME_W  = 24;
  localparam int LBYTE_W  = 40;
  localparam int BASE_W   = 40;
  localparam int STRIDE_W = 12;
  localparam int POS_W    = 41;
  localparam int OFFS_W   = 12;
  localparam int SLOT_W   = 7;
  localparam int PROD_W   = FRAME_W + STRIDE_W;

  localparam logic [FRAME_W-1:0] FRAME_MAX   = 24'hFFFFFF;
  localparam logic [7:0]         POINT_MIN   = 8'h01;
  localparam logic [7:0]         POINT_LIMIT = 8'hA0;

  // A frame holds 2352 = 16 * 147 bytes; the division by 147 uses a reciprocal.
  localparam int FRAME_SHIFT = 4;
  localparam int SCALED_W    = LBYTE_W - FRAME_SHIFT;
  localparam int RECIP_W     = 32;
  localparam int PROD_RW     = 2 * RECIP_W;
  localparam int RECIP_SHIFT = 39;
  localparam logic [7:0]          FRAME_ODD   = 8'd147;
  localparam logic [RECIP_W-1:0]  FRAME_RECIP = 32'd3739835469;
  localparam logic [SCALED_W-1:0] SCALED_OVF  = 36'd2466250752;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK    = 2'd1;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_XLATE = 1'b1;

  localparam logic [2:0] MODE_CODE_AUDIO = 3'h1;
  localparam logic [2:0] MODE_CODE_M1A   = 3'h2;
  localparam logic [2:0] MODE_CODE_M1B   = 3'h6;

  localparam logic [1:0] KIND_AUDIO = 2'd0;
  localparam logic [1:0] KIND_MODE1 = 2'd1;
  localparam logic [1:0] KIND_MODE2 = 2'd2;

  typedef enum logic [1:0] {
    ST_LOADED = 2'd0,
    ST_FOUND  = 2'd1,
    ST_GAP    = 2'd2,
    ST_PAST   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_REM,
    F_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SCAN,
    B_MUL,
    B_ADD,
    B_MISS
  } back_state_e;

  typedef struct packed {
    logic                op;
    logic [SLOT_W-1:0]   entry_index;
    logic [7:0]          track_point;
    logic [7:0]          track_mode;
    logic [FRAME_W-1:0]  first_frame;
    logic [FRAME_W-1:0]  frame_count;
    logic [BASE_W-1:0]   image_base;
    logic [STRIDE_W-1:0] stride;
    logic [LBYTE_W-1:0]  logical_byte;
  } item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [POS_W-1:0]   image_position;
    logic [SLOT_W-1:0]  hit_slot;
    logic [1:0]         track_kind;
    logic [FRAME_W-1:0] frame_number;
  } result_t;

  typedef struct packed {
    logic                is_load;
    logic [SLOT_W-1:0]   entry_index;
    logic                ok;
    logic [1:0]          kind;
    logic [FRAME_W-1:0]  start;
    logic [FRAME_W:0]    stop;
    logic [BASE_W-1:0]   base;
    logic [STRIDE_W-1:0] stride;
    logic                ovf;
    logic [FRAME_W-1:0]  frame;
    logic [OFFS_W-1:0]   in_frame;
  } cmd_t;

  typedef struct packed {
    logic [FRAME_W-1:0]  start;
    logic [FRAME_W:0]    stop;
    logic [BASE_W-1:0]   base;
    logic [STRIDE_W-1:0] stride;
    logic [1:0]          kind;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [7:0]         entry_count;
    logic [FRAME_W-1:0] fallback_frames;
  } cfg_t;

  function automatic logic [1:0] kind_of(logic [7:0] mode);
    logic [1:0] kind;
    case (mode[2:0])
      MODE_CODE_AUDIO: kind = KIND_AUDIO;
      MODE_CODE_M1A, MODE_CODE_M1B: kind = KIND_MODE1;
      default: kind = KIND_MODE2;
    endcase
    return kind;
  endfunction

endpackage

/* src/dttl_ram.sv */
// Generic single write port, single read port RAM with registered read data.
// Parameter defaults come from dttl_pkg.
module dttl_ram #(
  parameter int WIDTH = dttl_pkg::ENTRY_W,
  parameter int DEPTH = dttl_pkg::MAX_ENTRIES_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/dttl_front.sv */
// Front end: accepts words, builds table load commands and splits byte offsets
// into frame number and in-frame offset by reciprocal multiplication. Uses dttl_pkg.
module dttl_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  dttl_pkg::item_t item_i,
  output logic            busy_o,
  output logic            push_o,
  output dttl_pkg::cmd_t  cmd_o,
  input  logic            full_i
);
  import dttl_pkg::*;

  front_state_e          state_q, state_d;
  logic [LBYTE_W-1:0]    lb_q, lb_d;
  logic [PROD_RW-1:0]    prod_q, prod_d;
  logic                  ovf_q, ovf_d;
  logic [FRAME_W-1:0]    frame_q, frame_d;
  logic [OFFS_W-1:0]     rem_q, rem_d;
  logic                  accept;
  logic [SCALED_W-1:0]   scaled;
  logic [FRAME_W-1:0]    quot;
  logic [7:0]            odd_rem;

  assign busy_o  = (state_q != F_IDLE) || full_i;
  assign accept  = start_i && !busy_o;
  assign scaled  = lb_q[LBYTE_W-1:FRAME_SHIFT];
  assign quot    = prod_q[RECIP_SHIFT +: FRAME_W];
  assign odd_rem = scaled[7:0] - 8'(quot[7:0] * FRAME_ODD);

  always_comb begin
    state_d = state_q;
    lb_d    = lb_q;
    prod_d  = prod_q;
    ovf_d   = ovf_q;
    frame_d = frame_q;
    rem_d   = rem_q;
    push_o  = 1'b0;
    cmd_o   = '0;
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          if (item_i.op == OP_LOAD) begin
            push_o            = 1'b1;
            cmd_o.is_load     = 1'b1;
            cmd_o.entry_index = item_i.entry_index;
            cmd_o.ok          = (item_i.track_point >= POINT_MIN) &&
                                (item_i.track_point < POINT_LIMIT);
            cmd_o.kind        = kind_of(item_i.track_mode);
            cmd_o.start       = item_i.first_frame;
            cmd_o.stop        = {1'b0, item_i.first_frame} + {1'b0, item_i.frame_count};
            cmd_o.base        = item_i.image_base;
            cmd_o.stride      = item_i.stride;
          end else begin
            lb_d    = item_i.logical_byte;
            state_d = F_MUL;
          end
        end
      end
      F_MUL: begin
        prod_d  = PROD_RW'(scaled[RECIP_W-1:0]) * PROD_RW'(FRAME_RECIP);
        ovf_d   = scaled >= SCALED_OVF;
        state_d = F_REM;
      end
      F_REM: begin
        frame_d = quot;
        rem_d   = {odd_rem, lb_q[FRAME_SHIFT-1:0]};
        state_d = F_PUSH;
      end
      F_PUSH: begin
        cmd_o.ovf      = ovf_q;
        cmd_o.frame    = ovf_q ? FRAME_MAX : frame_q;
        cmd_o.in_frame = rem_q;
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = F_IDLE;
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lb_q    <= lb_d;
    prod_q  <= prod_d;
    ovf_q   <= ovf_d;
    frame_q <= frame_d;
    rem_q   <= rem_d;
  end

endmodule

/* src/dttl_fifo.sv */
// Short command queue between the front end and the table engine.
// Uses the command type of dttl_pkg.
module dttl_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  dttl_pkg::cmd_t data_i,
  input  logic           pop_i,
  output dttl_pkg::cmd_t data_o,
  output logic           full_o,
  output logic           empty_o
);
  import dttl_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  cmd_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;

  assign full_o  = cnt_q == CNT_W'(QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_LAST) ? '0 : wr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_LAST) ? '0 : rd_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

/* src/dttl_back.sv */
// Table engine: writes table entries, scans them one per cycle for a hit and
// computes the image position. Uses dttl_pkg and the assertion macros.
`include "disc_track_table_lba_mapper_macros.svh"

module dttl_back #(
  parameter int MAX_ENTRIES = dttl_pkg::MAX_ENTRIES_DEF,
  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
  localparam int CW = $clog2(MAX_ENTRIES + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dttl_pkg::cfg_t    cfg_i,
  input  dttl_pkg::cmd_t    cmd_i,
  input  logic              cmd_valid_i,
  output logic              cmd_pop_o,
  output logic              ram_we_o,
  output logic [AW-1:0]     ram_waddr_o,
  output dttl_pkg::entry_t  ram_wdata_o,
  output logic              ram_re_o,
  output logic [AW-1:0]     ram_raddr_o,
  input  dttl_pkg::entry_t  ram_rdata_i,
  output logic              done_o,
  output dttl_pkg::result_t result_o
);
  import dttl_pkg::*;

  back_state_e             state_q, state_d;
  logic [CW-1:0]           ia_q, ia_d;
  logic [CW-1:0]           n_q, n_d;
  logic                    chk_v_q, chk_v_d;
  logic [AW-1:0]           chk_idx_q, chk_idx_d;
  logic [MAX_ENTRIES-1:0]  valid_q, valid_d;
  logic [FRAME_W-1:0]      disc_q, disc_d;
  logic                    done_q, done_d;
  result_t                 res_q, res_d;
  logic [FRAME_W-1:0]      frame_q, frame_d;
  logic [OFFS_W-1:0]       inf_q, inf_d;
  logic [FRAME_W-1:0]      off_q, off_d;
  logic [STRIDE_W-1:0]     stride_q, stride_d;
  logic [BASE_W-1:0]       base_q, base_d;
  logic [1:0]              kind_q, kind_d;
  logic [SLOT_W-1:0]       slot_q, slot_d;
  logic [PROD_W-1:0]       prod_q, prod_d;
  logic                    hit;
  logic [FRAME_W-1:0]      stop_sat;
  logic [FRAME_W-1:0]      end_frames;

  assign hit = chk_v_q && valid_q[chk_idx_q] && (frame_q >= ram_rdata_i.start) &&
               ({1'b0, frame_q} < ram_rdata_i.stop);
  assign stop_sat   = cmd_i.stop[FRAME_W] ? FRAME_MAX : cmd_i.stop[FRAME_W-1:0];
  assign end_frames = (disc_q != '0) ? disc_q : cfg_i.fallback_frames;

  always_comb begin
    state_d   = state_q;
    ia_d      = ia_q;
    n_d       = n_q;
    chk_v_d   = chk_v_q;
    chk_idx_d = chk_idx_q;
    valid_d   = valid_q;
    disc_d    = disc_q;
    done_d    = 1'b0;
    res_d     = res_q;
    frame_d   = frame_q;
    inf_d     = inf_q;
    off_d     = off_q;
    stride_d  = stride_q;
    base_d    = base_q;
    kind_d    = kind_q;
    slot_d    = slot_q;
    prod_d    = prod_q;

    cmd_pop_o          = 1'b0;
    ram_we_o           = 1'b0;
    ram_waddr_o        = AW'(cmd_i.entry_index);
    ram_wdata_o.start  = cmd_i.start;
    ram_wdata_o.stop   = cmd_i.stop;
    ram_wdata_o.base   = cmd_i.base;
    ram_wdata_o.stride = cmd_i.stride;
    ram_wdata_o.kind   = cmd_i.kind;
    ram_re_o           = 1'b0;
    ram_raddr_o        = ia_q[AW-1:0];

    case (state_q)
      B_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.is_load) begin
            if (32'(cmd_i.entry_index) < MAX_ENTRIES) begin
              ram_we_o = 1'b1;
              valid_d[AW'(cmd_i.entry_index)] = cmd_i.ok;
              if (cmd_i.ok && (stop_sat > disc_q)) begin
                disc_d = stop_sat;
              end
            end
            done_d       = 1'b1;
            res_d        = '0;
            res_d.status = ST_LOADED;
          end else if (cmd_i.ovf) begin
            done_d             = 1'b1;
            res_d              = '0;
            res_d.status       = ST_PAST;
            res_d.frame_number = FRAME_MAX;
          end else begin
            frame_d = cmd_i.frame;
            inf_d   = cmd_i.in_frame;
            n_d     = (32'(cfg_i.entry_count) > MAX_ENTRIES) ? CW'(MAX_ENTRIES) :
                      CW'(cfg_i.entry_count);
            ia_d    = '0;
            chk_v_d = 1'b0;
            state_d = B_SCAN;
          end
        end
      end
      B_SCAN: begin
        if (hit) begin
          off_d    = frame_q - ram_rdata_i.start;
          stride_d = ram_rdata_i.stride;
          base_d   = ram_rdata_i.base;
          kind_d   = ram_rdata_i.kind;
          slot_d   = SLOT_W'(chk_idx_q);
          chk_v_d  = 1'b0;
          state_d  = B_MUL;
        end else if (ia_q < n_q) begin
          ram_re_o  = 1'b1;
          chk_v_d   = 1'b1;
          chk_idx_d = ia_q[AW-1:0];
          ia_d      = ia_q + CW'(1);
        end else begin
          chk_v_d = 1'b0;
          state_d = B_MISS;
        end
      end
      B_MUL: begin
        prod_d  = off_q * stride_q;
        state_d = B_ADD;
      end
      B_ADD: begin
        done_d               = 1'b1;
        res_d.status         = ST_FOUND;
        res_d.image_position = POS_W'(base_q) + POS_W'(prod_q) + POS_W'(inf_q);
        res_d.hit_slot       = slot_q;
        res_d.track_kind     = kind_q;
        res_d.frame_number   = frame_q;
        state_d              = B_IDLE;
      end
      B_MISS: begin
        done_d             = 1'b1;
        res_d              = '0;
        res_d.status       = (frame_q < end_frames) ? ST_GAP : ST_PAST;
        res_d.frame_number = frame_q;
        state_d            = B_IDLE;
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= B_IDLE;
      ia_q      <= '0;
      n_q       <= '0;
      chk_v_q   <= 1'b0;
      chk_idx_q <= '0;
      valid_q   <= '0;
      disc_q    <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      ia_q      <= ia_d;
      n_q       <= n_d;
      chk_v_q   <= chk_v_d;
      chk_idx_q <= chk_idx_d;
      valid_q   <= valid_d;
      disc_q    <= disc_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q    <= res_d;
    frame_q  <= frame_d;
    inf_q    <= inf_d;
    off_q    <= off_d;
    stride_q <= stride_d;
    base_q   <= base_d;
    kind_q   <= kind_d;
    slot_q   <= slot_d;
    prod_q   <= prod_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  `DTTL_ASSERT_IMP(a_scan_bound, state_q == B_SCAN, ia_q <= n_q, "Scan index ran past the slot limit.")
  `DTTL_ASSERT_NXT(a_mul_then_add, state_q == B_MUL, state_q == B_ADD, "Product was not followed by the final add.")
  `DTTL_ASSERT_IMP(a_miss_zero, done_o && (result_o.status != ST_FOUND), (result_o.image_position == '0) && (result_o.hit_slot == '0), "A result without a hit carries a position or slot.")

endmodule

/* src/disc_track_table_lba_mapper.sv */
// Load word: the engine pops the command, writes the entry and raises the registered result
// strobe; busy only while the queue is full. Translate word: busy while the offset is split
// (multiply, remainder, push); on frame overflow the engine answers without a scan, else it
// scans up to entry_count slots and reports a miss or a hit position; queued words go first.
// Reset is asynchronous and active low: control, valid bits, disc length and config clear
// at once; table RAM contents stay undefined until loaded. Results cannot be stalled.
module disc_track_table_lba_mapper #(
  parameter int MAX_ENTRIES = dttl_pkg::MAX_ENTRIES_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  dttl_pkg::item_t                      item_i,
  output logic                                 done_o,
  output dttl_pkg::result_t                    result_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [dttl_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [dttl_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import dttl_pkg::*;

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  cfg_t          cfg_q;
  logic          push;
  cmd_t          push_cmd;
  cmd_t          head_cmd;
  logic          full;
  logic          empty;
  logic          pop;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  entry_t        ram_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_ENTRY_COUNT: cfg_q.entry_count     <= cfg_data_i[7:0];
        CFG_FALLBACK:    cfg_q.fallback_frames <= cfg_data_i[FRAME_W-1:0];
        default: begin
        end
      endcase
    end
  end

  dttl_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .item_i (item_i),
    .busy_o (busy),
    .push_o (push),
    .cmd_o  (push_cmd),
    .full_i (full)
  );

  dttl_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_cmd),
    .pop_i  (pop),
    .data_o (head_cmd),
    .full_o (full),
    .empty_o(empty)
  );

  dttl_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_ENTRIES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  dttl_back #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .cmd_i      (head_cmd),
    .cmd_valid_i(!empty),
    .cmd_pop_o  (pop),
    .ram_we_o   (ram_we),
    .ram_waddr_o(ram_waddr),
    .ram_wdata_o(ram_wdata),
    .ram_re_o   (ram_re),
    .ram_raddr_o(ram_raddr),
    .ram_rdata_i(ram_rdata),
    .done_o     (done_o),
    .result_o   (result_o)
  );

endmodule
